@@ rtl/core/b64sc_pkg.sv @@
// Package for the base64 stream codec: payload structs, the job passed from the
// front end to the back end, and the alphabet conversion functions.
// Depends on nothing; every other file of the codec refers to it by scoped names.
package b64sc_pkg;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [6:0] SEXTET_PAD = 7'd64;
	localparam logic [6:0] SEXTET_BAD = 7'd127;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_error;
		logic       out_last;
	} result_t;

	typedef enum logic [1:0] {
		JOB_ENCODE,
		JOB_DECODE,
		JOB_ERROR
	} job_kind_t;

	// For an encode job, used is the number of real bytes (1..3) in the group;
	// for a decode job it is the number of bytes to emit (1..3).
	typedef struct packed {
		job_kind_t   kind;
		logic [1:0]  used;
		logic [23:0] bits;
	} job_t;

	function automatic logic [7:0] alphabet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'(8'd65 + {2'b00, v});
		end else if (v < 6'd52) begin
			c = 8'(8'd71 + {2'b00, v});
		end else if (v < 6'd62) begin
			c = 8'({2'b00, v} - 8'd4);
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] s;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 7'(c - 8'd71);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 7'(c + 8'd4);
		end else if (c == 8'h2B) begin
			s = 7'd62;
		end else if (c == 8'h2F) begin
			s = 7'd63;
		end else if (c == PAD_CHAR) begin
			s = SEXTET_PAD;
		end else begin
			s = SEXTET_BAD;
		end
		return s;
	endfunction

endpackage

@@ rtl/core/b64sc_front.sv @@
// Front end of the base64 stream codec: holds the mode register and the open
// group, classifies each accepted byte and issues at most one job per transaction.
// Depends on b64sc_pkg.
module b64sc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic                cfg_data,
	input  logic                accept,
	input  b64sc_pkg::in_item_t item,
	output logic                job_valid,
	output b64sc_pkg::job_t     job
);

	logic        mode_q;
	logic [17:0] group_bits_q;
	logic [1:0]  group_count_q;
	logic        halted_q;
	logic [1:0]  pad_seen_q;

	logic [17:0] group_bits_d;
	logic [1:0]  group_count_d;
	logic        halted_d;
	logic [1:0]  pad_seen_d;

	logic [2:0]  enc_cnt;
	logic [23:0] enc_bits;
	logic [6:0]  sextet;
	logic [5:0]  sextet_val;
	logic [1:0]  pad_next;

	always_comb begin
		group_bits_d  = group_bits_q;
		group_count_d = group_count_q;
		halted_d      = halted_q;
		pad_seen_d    = pad_seen_q;
		job_valid     = 1'b0;
		job.kind      = b64sc_pkg::JOB_ENCODE;
		job.used      = 2'd0;
		job.bits      = 24'd0;
		enc_cnt       = {1'b0, group_count_q} + 3'd1;
		enc_bits      = {group_bits_q[15:0], item.in_byte};
		sextet        = b64sc_pkg::sextet_of(item.in_byte);
		sextet_val    = sextet[5:0];
		pad_next      = pad_seen_q;

		if (mode_q == b64sc_pkg::MODE_ENCODE) begin
			if (enc_cnt == 3'd3 || item.end_of_stream) begin
				job_valid = 1'b1;
				job.kind  = b64sc_pkg::JOB_ENCODE;
				job.used  = enc_cnt[1:0];
				// Left-align a short group so the missing bytes read as zero.
				unique case (enc_cnt)
					3'd1:    job.bits = {enc_bits[7:0], 16'd0};
					3'd2:    job.bits = {enc_bits[15:0], 8'd0};
					default: job.bits = enc_bits;
				endcase
				group_bits_d  = 18'd0;
				group_count_d = 2'd0;
			end else begin
				group_bits_d  = {2'b00, enc_bits[15:0]};
				group_count_d = enc_cnt[1:0];
			end
		end else if (!halted_q) begin
			if (sextet == b64sc_pkg::SEXTET_BAD
					|| (sextet == b64sc_pkg::SEXTET_PAD && group_count_q < 2'd2)) begin
				job_valid     = 1'b1;
				job.kind      = b64sc_pkg::JOB_ERROR;
				job.used      = 2'd1;
				group_bits_d  = 18'd0;
				group_count_d = 2'd0;
				pad_seen_d    = 2'd0;
				halted_d      = 1'b1;
			end else begin
				if (sextet == b64sc_pkg::SEXTET_PAD) begin
					pad_next   = pad_seen_q | ((group_count_q == 2'd2) ? 2'b10 : 2'b01);
					sextet_val = 6'd0;
				end
				if (group_count_q == 2'd3) begin
					job_valid = 1'b1;
					job.kind  = b64sc_pkg::JOB_DECODE;
					job.bits  = {group_bits_q, sextet_val};
					if (pad_next[1]) begin
						job.used = 2'd1;
					end else if (pad_next[0]) begin
						job.used = 2'd2;
					end else begin
						job.used = 2'd3;
					end
					group_bits_d  = 18'd0;
					group_count_d = 2'd0;
					pad_seen_d    = 2'd0;
				end else begin
					group_bits_d  = {group_bits_q[11:0], sextet_val};
					group_count_d = 2'(group_count_q + 2'd1);
					pad_seen_d    = pad_next;
				end
			end
		end

		if (item.end_of_stream) begin
			group_bits_d  = 18'd0;
			group_count_d = 2'd0;
			halted_d      = 1'b0;
			pad_seen_d    = 2'd0;
		end

		if (!accept) begin
			job_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= b64sc_pkg::MODE_ENCODE;
			group_bits_q  <= 18'd0;
			group_count_q <= 2'd0;
			halted_q      <= 1'b0;
			pad_seen_q    <= 2'd0;
		end else if (cfg_write) begin
			// A mode change starts a fresh stream.
			mode_q        <= cfg_data;
			group_bits_q  <= 18'd0;
			group_count_q <= 2'd0;
			halted_q      <= 1'b0;
			pad_seen_q    <= 2'd0;
		end else if (accept) begin
			group_bits_q  <= group_bits_d;
			group_count_q <= group_count_d;
			halted_q      <= halted_d;
			pad_seen_q    <= pad_seen_d;
		end
	end

endmodule

@@ rtl/core/b64sc_job_queue.sv @@
// Short job queue between the front and back ends of the base64 stream codec.
// Depends on b64sc_pkg for the job struct.
module b64sc_job_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  b64sc_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output b64sc_pkg::job_t rd_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	b64sc_pkg::job_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
			end
			if (wr_en && !rd_en) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (rd_en && !wr_en) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/core/b64sc_back.sv @@
// Back end of the base64 stream codec: expands each queued job into its result
// items into a registered output slot, one per cycle while it is empty or popped.
// Depends on b64sc_pkg.
module b64sc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  b64sc_pkg::job_t    job,
	output logic               job_done,
	output logic               empty,
	input  logic               pop,
	output b64sc_pkg::result_t result
);

	logic [1:0]         idx_q;
	logic               out_valid_q;
	b64sc_pkg::result_t out_q;

	logic               load;
	logic [1:0]         last_idx;
	logic [5:0]         sextet;
	logic [7:0]         data_byte;
	b64sc_pkg::result_t next_res;

	assign load = job_valid && (!out_valid_q || pop);

	always_comb begin
		unique case (idx_q)
			2'd0: sextet = job.bits[23:18];
			2'd1: sextet = job.bits[17:12];
			2'd2: sextet = job.bits[11:6];
			2'd3: sextet = job.bits[5:0];
		endcase
		unique case (idx_q)
			2'd0:    data_byte = job.bits[23:16];
			2'd1:    data_byte = job.bits[15:8];
			default: data_byte = job.bits[7:0];
		endcase

		next_res.out_error = 1'b0;
		unique case (job.kind)
			b64sc_pkg::JOB_ENCODE: begin
				last_idx = 2'd3;
				// Characters past the real bytes become padding.
				next_res.out_byte = (idx_q > job.used) ? b64sc_pkg::PAD_CHAR
				                                       : b64sc_pkg::alphabet_char(sextet);
			end
			b64sc_pkg::JOB_DECODE: begin
				last_idx          = 2'(job.used - 2'd1);
				next_res.out_byte = data_byte;
			end
			default: begin
				last_idx           = 2'd0;
				next_res.out_byte  = 8'd0;
				next_res.out_error = 1'b1;
			end
		endcase
		next_res.out_last = (idx_q == last_idx);
		job_done          = load && next_res.out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= next_res.out_last ? 2'd0 : 2'(idx_q + 2'd1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ rtl/core/base64_stream_codec.sv @@
// Base64 stream codec (RFC 4648), encode and decode selected by a mode register.
//
// Input channel: an item (one byte and an end-of-stream flag) is taken at a clock
// edge where push is high and full is low. Result channel: while empty is low the
// oldest result sits on result; it is taken at an edge where pop is high.
// Configuration: cfg_data (the mode, 0 encode, 1 decode) is written when cfg_valid
// and cfg_ready are high; cfg_ready is always high. Write it only while idle; a
// write also discards any open group and restarts the stream.
//
// The front end takes one item per cycle while full is low and turns each group
// into one job; the back end expands a job into one to four results at one
// result per cycle while its output slot is empty or popped. An item's job passes
// through the queue and then the registered output slot. Encoding is bound by the
// single result port, as three input items make four results; decoding sustains
// one item per cycle while results are taken.
// When the receiver stalls, jobs collect in a queue of QUEUE_DEPTH entries and full
// rises once every entry is occupied. After reset the mode is encode, all stream
// state is clear and both channels are empty.
module base64_stream_codec #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  b64sc_pkg::in_item_t item,
	output logic                empty,
	input  logic                pop,
	output b64sc_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic            accept;
	logic            cfg_write;
	logic            new_job_valid;
	b64sc_pkg::job_t new_job;
	logic            head_valid;
	b64sc_pkg::job_t head_job;
	logic            head_done;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign accept    = push && !full;

	b64sc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.job_valid (new_job_valid),
		.job       (new_job)
	);

	b64sc_job_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (new_job_valid),
		.wr_job   (new_job),
		.full     (full),
		.rd_en    (head_done),
		.rd_valid (head_valid),
		.rd_job   (head_job)
	);

	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.job_done  (head_done),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
